### rtl/core/bsa_pkg.sv
package bsa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned BIT_IDX_W     = 5;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned ESIZE_W   = 13;
  localparam int unsigned OFFS_W    = 22;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 11;

  localparam logic [ESIZE_W-1:0]   ESIZE_RST = ESIZE_W'(1);
  localparam logic [WORD_BITS-1:0] ALL_FREE  = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TRIM    = 2'd2,
    MODE_LOOKUP  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOTRIM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_PTR  = 2'd0,
    RD_SLOT = 2'd1,
    RD_TRIM = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    start;
    logic    grow;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ptr_inc;
    logic    alloc_commit;
    logic    rel_commit;
    logic    trim_drop;
    logic    trim_clamp;
    logic    set_full;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_grow;
    logic at_max;
    logic ptr_end;
    logic word_nz;
    logic word_free;
    logic pw_zero;
    logic rel_ok;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/bsa_ctrl.sv
module bsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bsa_pkg::mode_t    in_mode,
  output logic              in_ready,
  input  bsa_pkg::dp_stat_t stat,
  output bsa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ALLOC_CK = 10'b00_0000_0010,
    S_SCAN_RD  = 10'b00_0000_0100,
    S_SCAN_CHK = 10'b00_0000_1000,
    S_REL_RD   = 10'b00_0001_0000,
    S_REL_WR   = 10'b00_0010_0000,
    S_TRIM_RD  = 10'b00_0100_0000,
    S_TRIM_CHK = 10'b00_1000_0000,
    S_TRIM_END = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (in_mode)
            bsa_pkg::MODE_ALLOC:   state_nxt = S_ALLOC_CK;
            bsa_pkg::MODE_RELEASE: state_nxt = S_REL_RD;
            bsa_pkg::MODE_TRIM:    state_nxt = S_TRIM_RD;
            bsa_pkg::MODE_LOOKUP:  state_nxt = S_DONE;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_ALLOC_CK: begin
        if (stat.need_grow && stat.at_max) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.grow  = stat.need_grow;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.ptr_end) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bsa_pkg::RD_PTR;
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.word_nz) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_REL_RD: begin
        if (stat.rel_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bsa_pkg::RD_SLOT;
          state_nxt  = S_REL_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_REL_WR: begin
        cmd.rel_commit = 1'b1;
        state_nxt      = S_DONE;
      end
      S_TRIM_RD: begin
        if (stat.pw_zero) begin
          state_nxt = S_TRIM_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bsa_pkg::RD_TRIM;
          state_nxt  = S_TRIM_CHK;
        end
      end
      S_TRIM_CHK: begin
        if (stat.word_free) begin
          cmd.trim_drop = 1'b1;
          state_nxt     = S_TRIM_RD;
        end else begin
          state_nxt = S_TRIM_END;
        end
      end
      S_TRIM_END: begin
        cmd.trim_clamp = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/bsa_dp.sv
module bsa_dp #(
  parameter int unsigned MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bsa_pkg::dp_cmd_t                cmd,
  output bsa_pkg::dp_stat_t               stat,
  input  logic [bsa_pkg::SLOT_W-1:0]      in_slot,
  input  logic                            cfg_wen,
  input  logic [bsa_pkg::ESIZE_W-1:0]     cfg_wdata,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [bsa_pkg::SLOT_W-1:0]      out_granted,
  output logic [bsa_pkg::OFFS_W-1:0]      out_offset,
  output logic [bsa_pkg::STAT_W-1:0]      out_status,
  output logic [bsa_pkg::CNT_OUT_W-1:0]   out_active,
  output logic [bsa_pkg::CNT_OUT_W-1:0]   out_capacity
);

  localparam int unsigned MAP_WORDS = MAX_SLOTS / bsa_pkg::WORD_BITS;
  localparam int unsigned WW        = $clog2(MAP_WORDS + 1);
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = bsa_pkg::BIT_IDX_W;
  localparam int unsigned CW        = WW + BW;
  localparam int unsigned SW        = $clog2(MAX_SLOTS);
  localparam int unsigned GW        = (SW > bsa_pkg::SLOT_W) ? SW : bsa_pkg::SLOT_W;
  localparam int unsigned SWORD_W   = bsa_pkg::SLOT_W - BW;
  localparam int unsigned CMPW      = (WW > SWORD_W) ? WW : SWORD_W;
  localparam int unsigned PW        = GW + bsa_pkg::ESIZE_W;

  function automatic logic [BW-1:0] lowest_set(input logic [bsa_pkg::WORD_BITS-1:0] w);
    logic [BW-1:0] n;
    n = '0;
    for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = BW'(i);
    end
    return n;
  endfunction

  logic [bsa_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
  logic [bsa_pkg::WORD_BITS-1:0] rdata_r;

  logic [WW-1:0]                  pw_r;
  logic [CW-1:0]                  active_r;
  logic [WW-1:0]                  hint_r;
  logic [WW-1:0]                  ptr_r;
  logic [bsa_pkg::SLOT_W-1:0]     slot_r;
  logic [GW-1:0]                  granted_r;
  bsa_pkg::status_t               status_r;
  logic                           dropped_r;
  logic [bsa_pkg::ESIZE_W-1:0]    esize_r;

  logic                           out_valid_r;
  logic [bsa_pkg::SLOT_W-1:0]     out_granted_r;
  logic [bsa_pkg::OFFS_W-1:0]     out_offset_r;
  logic [bsa_pkg::STAT_W-1:0]     out_status_r;
  logic [bsa_pkg::CNT_OUT_W-1:0]  out_active_r;
  logic [bsa_pkg::CNT_OUT_W-1:0]  out_capacity_r;

  logic [SWORD_W-1:0]             slot_word;
  logic [BW-1:0]                  low_bit;
  logic [CW-1:0]                  cap_slots;
  logic [AW-1:0]                  mem_raddr;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [bsa_pkg::WORD_BITS-1:0]  mem_wdata;
  logic [PW-1:0]                  prod;

  assign slot_word = slot_r[bsa_pkg::SLOT_W-1:BW];
  assign low_bit   = lowest_set(rdata_r);
  assign cap_slots = {pw_r, {BW{1'b0}}};
  assign prod      = PW'(granted_r) * PW'(esize_r);

  assign stat.need_grow = (active_r >= cap_slots);
  assign stat.at_max    = (pw_r == WW'(MAP_WORDS));
  assign stat.ptr_end   = (ptr_r >= pw_r);
  assign stat.word_nz   = (rdata_r != '0);
  assign stat.word_free = (rdata_r == bsa_pkg::ALL_FREE);
  assign stat.pw_zero   = (pw_r == '0);
  assign stat.rel_ok    = (CMPW'(slot_word) < CMPW'(pw_r));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      bsa_pkg::RD_PTR:  mem_raddr = AW'(ptr_r);
      bsa_pkg::RD_SLOT: mem_raddr = AW'(slot_word);
      bsa_pkg::RD_TRIM: mem_raddr = AW'(pw_r - WW'(1));
      default:          mem_raddr = '0;
    endcase
  end

  // one write port: fresh word on growth, bit clear on grant, bit set on release
  always_comb begin
    mem_we    = cmd.grow || cmd.alloc_commit || cmd.rel_commit;
    mem_waddr = AW'(pw_r);
    mem_wdata = bsa_pkg::ALL_FREE;
    if (cmd.alloc_commit) begin
      mem_waddr = AW'(ptr_r);
      mem_wdata = rdata_r & ~(bsa_pkg::WORD_BITS'(1) << low_bit);
    end else if (cmd.rel_commit) begin
      mem_waddr = AW'(slot_word);
      mem_wdata = rdata_r | (bsa_pkg::WORD_BITS'(1) << slot_r[BW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      slot_r    <= in_slot;
      granted_r <= GW'(in_slot);
      status_r  <= bsa_pkg::ST_OK;
      dropped_r <= 1'b0;
      ptr_r     <= hint_r;
    end else begin
      if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + WW'(1);
      end
      if (cmd.alloc_commit) begin
        granted_r <= GW'({ptr_r, low_bit});
      end
      if (cmd.set_full) begin
        status_r <= bsa_pkg::ST_FULL;
      end
      if (cmd.trim_drop) begin
        dropped_r <= 1'b1;
      end
      if (cmd.trim_clamp) begin
        status_r <= dropped_r ? bsa_pkg::ST_OK : bsa_pkg::ST_NOTRIM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r     <= '0;
      active_r <= '0;
      hint_r   <= '0;
      esize_r  <= bsa_pkg::ESIZE_RST;
    end else begin
      if (cfg_wen) begin
        esize_r <= cfg_wdata;
      end
      if (cmd.grow) begin
        pw_r <= pw_r + WW'(1);
      end
      if (cmd.trim_drop) begin
        pw_r <= pw_r - WW'(1);
      end
      if (cmd.alloc_commit) begin
        active_r <= active_r + CW'(1);
        hint_r   <= ptr_r;
      end
      if (cmd.rel_commit) begin
        if (active_r != '0) begin
          active_r <= active_r - CW'(1);
        end
        if (CMPW'(slot_word) < CMPW'(hint_r)) begin
          hint_r <= WW'(slot_word);
        end
      end
      if (cmd.trim_clamp && (hint_r > pw_r)) begin
        hint_r <= pw_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted_r  <= granted_r[bsa_pkg::SLOT_W-1:0];
      out_offset_r   <= prod[bsa_pkg::OFFS_W-1:0];
      out_status_r   <= status_r;
      out_active_r   <= bsa_pkg::CNT_OUT_W'(active_r);
      out_capacity_r <= bsa_pkg::CNT_OUT_W'(cap_slots);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_granted  = out_granted_r;
  assign out_offset   = out_offset_r;
  assign out_status   = out_status_r;
  assign out_active   = out_active_r;
  assign out_capacity = out_capacity_r;

endmodule

### rtl/core/bitmap_slot_allocator_core.sv
// bitmap slot allocator: hands out slots from a free map of 32-slot words (1 = free),
// growing the provisioned capacity one all-free word at a time and trimming trailing
// free words on request; one item is worked at a time and each gives one result.
// steps per item: a lookup goes straight to its result; a release reads the word of
// the slot and writes it back with that bit set, unless the slot lies beyond capacity;
// an allocate reports full when it must grow but the map is at its limit, else grows
// by one word when every provisioned slot is active, then reads words from the hint
// word on until one holds a free bit, reporting full when none does (the scan goes
// through the single read port of the map memory, whose read data is registered); a
// trim reads the last provisioned word and drops it while it is all free. while the
// output register holds a result not yet taken, the item waits in its last state.
// the map memory needs no clearing after reset, since a word is rewritten all-free
// when the capacity grows over it.
module bitmap_slot_allocator_core #(
  parameter int unsigned MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] slot, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] granted_slot, [31:10] byte_offset, [33:32] status,
  // [44:34] active_slots, [55:45] capacity
  output logic [55:0] out_tdata,
  // element size register
  input  logic        cfg_wen,
  input  logic [12:0] cfg_wdata
);

  bsa_pkg::dp_cmd_t  cmd;
  bsa_pkg::dp_stat_t stat;

  logic [bsa_pkg::SLOT_W-1:0]    granted;
  logic [bsa_pkg::OFFS_W-1:0]    offset;
  logic [bsa_pkg::STAT_W-1:0]    status;
  logic [bsa_pkg::CNT_OUT_W-1:0] active;
  logic [bsa_pkg::CNT_OUT_W-1:0] capacity;

  // sequencer: decides the step of each operation from datapath status
  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (bsa_pkg::mode_t'(in_tuser)),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // map memory, counters, hint, scan pointer and the output register
  bsa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_slot      (in_tdata[bsa_pkg::SLOT_W-1:0]),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_granted  (granted),
    .out_offset   (offset),
    .out_status   (status),
    .out_active   (active),
    .out_capacity (capacity)
  );

  assign out_tdata = {capacity, active, status, offset, granted};

  // a taken item keeps the port closed until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  // allocated slots always sit inside provisioned words
  a_active_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44:34] <= out_tdata[55:45]))
    else $error("active count above capacity");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:32] <= bsa_pkg::ST_NOTRIM))
    else $error("undefined status code");

endmodule

### test/slot_alloc_checker.sv
`timescale 1ns / 100ps

module slot_alloc_checker #(
  parameter int unsigned MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] slot, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] granted_slot, [31:10] byte_offset, [33:32] status,
  // [44:34] active_slots, [55:45] capacity
  input  logic [55:0] out_tdata,
  input  logic        cfg_wen,
  input  logic [12:0] cfg_wdata,
  output int unsigned errors,
  output int unsigned waiting
);

  import bsa_pkg::*;

  localparam int unsigned MAP_WORDS = MAX_SLOTS / WORD_BITS;

  // same bit layout as out_tdata
  typedef struct packed {
    logic [CNT_OUT_W-1:0] capacity;
    logic [CNT_OUT_W-1:0] active;
    status_t              status;
    logic [OFFS_W-1:0]    offset;
    logic [SLOT_W-1:0]    slot;
  } slot_result_t;

  logic [WORD_BITS-1:0] free_words [MAP_WORDS];
  int unsigned          cap_slots;
  int unsigned          used_slots;
  int unsigned          scan_from;
  logic [ESIZE_W-1:0]   slot_bytes;
  slot_result_t         result_q [$];

  initial begin
    errors  = 0;
    waiting = 0;
  end

  function automatic slot_result_t allocator_step(mode_t op, logic [SLOT_W-1:0] slot_in);
    slot_result_t r;
    int unsigned  w;
    int unsigned  b;
    int unsigned  words;
    int unsigned  cap_prior;
    logic         no_room;
    r        = '0;
    r.slot   = slot_in;
    r.status = ST_OK;
    no_room  = 1'b0;
    case (op)
      MODE_ALLOC: begin
        // grow by one all-free word when every provisioned slot is counted active
        if (used_slots >= cap_slots) begin
          if (cap_slots + WORD_BITS > MAX_SLOTS) begin
            no_room = 1'b1;
          end else begin
            free_words[cap_slots / WORD_BITS] = ALL_FREE;
            cap_slots += WORD_BITS;
          end
        end
        if (!no_room) begin
          words = cap_slots / WORD_BITS;
          w     = scan_from;
          while (w < words && free_words[w] == '0) w++;
          if (w < words) begin
            b = 0;
            while (b < WORD_BITS - 1 && !free_words[w][b]) b++;
            free_words[w][b] = 1'b0;
            used_slots++;
            scan_from = w;
            r.slot    = SLOT_W'(w * WORD_BITS + b);
          end else begin
            no_room = 1'b1;
          end
        end
        if (no_room) r.status = ST_FULL;
      end
      MODE_RELEASE: begin
        if (slot_in < cap_slots) begin
          w = slot_in / WORD_BITS;
          free_words[w][slot_in[BIT_IDX_W-1:0]] = 1'b1;
          if (used_slots > 0) used_slots--;
          if (w < scan_from) scan_from = w;
        end
      end
      MODE_TRIM: begin
        cap_prior = cap_slots;
        while (cap_slots > 0 && free_words[cap_slots / WORD_BITS - 1] == ALL_FREE)
          cap_slots -= WORD_BITS;
        if (scan_from > cap_slots / WORD_BITS) scan_from = cap_slots / WORD_BITS;
        if (cap_prior == cap_slots) r.status = ST_NOTRIM;
      end
      default: ;
    endcase
    r.offset   = OFFS_W'(int'(r.slot) * int'(slot_bytes));
    r.active   = CNT_OUT_W'(used_slots);
    r.capacity = CNT_OUT_W'(cap_slots);
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
    end
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t got;
    if (!rst_n) begin
      foreach (free_words[i]) free_words[i] = ALL_FREE;
      cap_slots  = 0;
      used_slots = 0;
      scan_from  = 0;
      slot_bytes = ESIZE_RST;
      result_q.delete();
    end else begin
      if (cfg_wen) slot_bytes = cfg_wdata;
      if (in_tvalid && in_tready)
        result_q.push_back(allocator_step(mode_t'(in_tuser), in_tdata[SLOT_W-1:0]));
      if (out_tvalid && out_tready) begin
        got = slot_result_t'(out_tdata);
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none actual %h",
                   $time, out_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("granted_slot", 32'(want.slot), 32'(got.slot));
          check_field("byte_offset", 32'(want.offset), 32'(got.offset));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("active_slots", 32'(want.active), 32'(got.active));
          check_field("capacity", 32'(want.capacity), 32'(got.capacity));
        end
      end
    end
    waiting <= result_q.size();
  end

endmodule

### test/tb_bitmap_slot_allocator_core.sv
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator_core;

  import bsa_pkg::*;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel, all driven to known values from time zero
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata  = '0;   // [9:0] slot, rest zero
  logic [1:0]  in_tuser  = '0;   // [1:0] mode

  // result channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [9:0] granted_slot, [31:10] byte_offset, [33:32] status,
  // [44:34] active_slots, [55:45] capacity
  logic [55:0] out_tdata;

  // element size register
  logic        cfg_wen   = 1'b0;
  logic [12:0] cfg_wdata = '0;

  // shared pacing controls between the sender and the receiver
  logic        no_gaps      = 1'b0;   // both sides run back to back while set
  logic        rx_long_hold = 1'b0;   // receiver stalls one long stretch when set

  int unsigned fail_count;
  int unsigned results_waiting;

  bitmap_slot_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  slot_alloc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .errors     (fail_count),
    .waiting    (results_waiting)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // overall watchdog, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_bitmap_slot_allocator_core NOT OK");
    $finish;
  end

  // offer one item after a random gap and hold it until the block takes it;
  // with no gap tvalid simply stays high and only the payload moves on
  task automatic push_item(mode_t op, logic [SLOT_W-1:0] slot);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, slot};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // stop offering and let every outstanding result drain, then a short
  // settle so the block is surely back in idle
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // element size is only changed while the block is idle
  task automatic set_element_size(logic [ESIZE_W-1:0] bytes);
    wait_results_done();
    cfg_wen   <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // receiver: random stall before each result, plus one long hold-off on request
  initial begin
    int unsigned rx_gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_long_hold) begin
        rx_gap       = 300;
        rx_long_hold = 1'b0;
      end else begin
        rx_gap = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (rx_gap != 0) begin
        out_tready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned pick;
    int unsigned k;
    int unsigned rnd;

    // synchronous reset held from time zero, then released
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lookups at the field extremes and on an empty map, element size
    // still at its reset value
    push_item(MODE_LOOKUP, 10'd0);
    push_item(MODE_LOOKUP, 10'd1023);
    // trim with nothing provisioned changes nothing
    push_item(MODE_TRIM, 10'd0);
    // release above capacity is ignored
    push_item(MODE_RELEASE, 10'd1023);
    // first allocate grows by one word
    push_item(MODE_ALLOC, 10'd0);
    push_item(MODE_ALLOC, 10'd0);
    push_item(MODE_ALLOC, 10'd0);
    // a freed slot is handed out again
    push_item(MODE_RELEASE, 10'd1);
    push_item(MODE_ALLOC, 10'd0);
    // alternating bit patterns on the slot field
    push_item(MODE_LOOKUP, 10'h2AA);
    push_item(MODE_LOOKUP, 10'h155);
    // trim with the last word in use changes nothing
    push_item(MODE_TRIM, 10'd0);

    // largest nominal element size: lookup of the top slot gives the largest offset
    set_element_size(13'd4096);
    push_item(MODE_LOOKUP, 10'd1023);
    push_item(MODE_RELEASE, 10'd0);
    push_item(MODE_RELEASE, 10'd1);
    push_item(MODE_RELEASE, 10'd2);
    // release of an already free slot with the active count at zero
    push_item(MODE_RELEASE, 10'd2);
    push_item(MODE_RELEASE, 10'd40);
    // now the word is all free and trim drops it
    push_item(MODE_TRIM, 10'd0);
    push_item(MODE_ALLOC, 10'd0);
    push_item(MODE_ALLOC, 10'd0);

    // fill the whole map and run into the capacity limit; the receiver holds
    // off for a long stretch at the start while the sender keeps offering
    no_gaps      = 1'b1;
    rx_long_hold = 1'b1;
    for (k = 0; k < 1030; k++) begin
      if (k == 200) no_gaps = 1'b0;
      push_item(MODE_ALLOC, SLOT_W'($urandom));
    end

    // element size that makes the offset wrap
    set_element_size(13'd8191);

    // free the top two words from the end down, then trim them away
    for (k = 0; k < 64; k++) push_item(MODE_RELEASE, SLOT_W'(1023 - k));
    push_item(MODE_TRIM, 10'd0);
    push_item(MODE_RELEASE, 10'd1000);
    push_item(MODE_TRIM, 10'd0);
    push_item(MODE_LOOKUP, SLOT_W'($urandom));

    // mixed rounds on a nearly full map: random allocates, releases (some of free
    // slots), trims and lookups, followed by an allocate burst that can find no free bit
    for (rnd = 0; rnd < 3; rnd++) begin
      case (rnd)
        0:       set_element_size(ESIZE_W'($urandom_range(1, 4096)));
        1:       set_element_size(13'd4096);
        default: set_element_size(13'd1);
      endcase
      no_gaps = (rnd == 1);
      for (k = 0; k < 60; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      push_item(MODE_ALLOC, SLOT_W'($urandom));
        else if (pick < 75) push_item(MODE_RELEASE, SLOT_W'($urandom_range(0, 1023)));
        else if (pick < 85) push_item(MODE_TRIM, SLOT_W'($urandom));
        else                push_item(MODE_LOOKUP, SLOT_W'($urandom));
      end
      for (k = 0; k < 15; k++) push_item(MODE_ALLOC, SLOT_W'($urandom));
    end
    no_gaps = 1'b0;

    // drain and give the block time to settle before the verdict
    wait_results_done();
    repeat (80) @(posedge clk);
    if (fail_count == 0)
      $display("tb_bitmap_slot_allocator_core OK");
    else
      $display("tb_bitmap_slot_allocator_core NOT OK");
    $finish;
  end

endmodule
